[design/bd_pkg.sv]
// ----------------------------------------------------------------------------
// bd_pkg
// Shared types and constants for the bounded deque.
// ----------------------------------------------------------------------------
package bd_pkg;

    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;
    localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W      = $clog2(DEPTH + 1);

    localparam int OP_W       = 3;
    localparam int VALUE_W    = 32;
    localparam int STATUS_W   = 2;
    localparam int COUNT_W    = 5;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_PEEK_FRONT = 3'd4,
        OP_PEEK_BACK  = 3'd5
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        STS_OK    = 2'd0,
        STS_EMPTY = 2'd1,
        STS_FULL  = 2'd2
    } status_t;

    typedef enum logic {
        S_IDLE,
        S_READ
    } fsm_t;

    // slot memory access issued by the controller
    typedef struct packed {
        logic                  we;
        logic [IDX_W-1:0]      waddr;
        logic [DATA_WIDTH-1:0] wdata;
        logic [IDX_W-1:0]      raddr;
    } ram_cmd_t;

    // output register contents
    typedef struct packed {
        logic                valid;
        logic [VALUE_W-1:0]  value;
        status_t             status;
        logic [COUNT_W-1:0]  count;
    } result_t;

endpackage

[design/bd_ram.sv]
// ----------------------------------------------------------------------------
// bd_ram
// Generic simple dual-port RAM, one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module bd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[design/bd_ctrl.sv]
// ----------------------------------------------------------------------------
// bd_ctrl
// Ring indices, entry count, request sequencer and output register.
// ----------------------------------------------------------------------------
module bd_ctrl
    import bd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [OP_W-1:0]       opcode,
    input  logic [VALUE_W-1:0]    push_value,
    output ram_cmd_t              ram_cmd,
    input  logic [DATA_WIDTH-1:0] ram_rdata,
    input  logic                  m_ready,
    output result_t               result
);

    fsm_t             state_reg, state_next;
    logic [IDX_W-1:0] front_reg, front_next;
    logic [IDX_W-1:0] back_reg,  back_next;
    logic [CNT_W-1:0] count_reg, count_next;

    logic               out_valid_reg, out_valid_next;
    logic [VALUE_W-1:0] out_value_reg, out_value_next;
    status_t            out_status_reg, out_status_next;
    logic [COUNT_W-1:0] out_count_reg, out_count_next;

    logic             accept;
    logic             need_read;
    logic             is_full;
    logic             is_empty;
    status_t          req_status;
    logic [IDX_W-1:0] front_inc, front_dec, back_inc, back_dec;

    function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] i);
        return (i == IDX_W'(DEPTH - 1)) ? '0 : i + IDX_W'(1);
    endfunction

    function automatic logic [IDX_W-1:0] wrap_dec(input logic [IDX_W-1:0] i);
        return (i == '0) ? IDX_W'(DEPTH - 1) : i - IDX_W'(1);
    endfunction

    assign front_inc = wrap_inc(front_reg);
    assign front_dec = wrap_dec(front_reg);
    assign back_inc  = wrap_inc(back_reg);
    assign back_dec  = wrap_dec(back_reg);
    assign is_full   = (count_reg == CNT_W'(DEPTH));
    assign is_empty  = (count_reg == '0);

    // output slot is free at accept, so the read cycle can always load it
    assign s_ready = (state_reg == S_IDLE) && (!out_valid_reg || m_ready);
    assign accept  = s_valid && s_ready;

    // request decode: ring update and memory access
    always_comb
    begin
        front_next      = front_reg;
        back_next       = back_reg;
        count_next      = count_reg;
        need_read       = 1'b0;
        req_status      = STS_OK;
        ram_cmd.we      = 1'b0;
        ram_cmd.waddr   = back_reg;
        ram_cmd.wdata   = DATA_WIDTH'(push_value);
        ram_cmd.raddr   = front_reg;
        case (op_t'(opcode))
            OP_PUSH_FRONT, OP_PUSH_BACK:
            begin
                if (is_full)
                begin
                    req_status = STS_FULL;
                end
                else if (op_t'(opcode) == OP_PUSH_FRONT)
                begin
                    front_next    = front_dec;
                    ram_cmd.we    = accept;
                    ram_cmd.waddr = front_dec;
                    count_next    = count_reg + CNT_W'(1);
                end
                else
                begin
                    back_next     = back_inc;
                    ram_cmd.we    = accept;
                    ram_cmd.waddr = back_reg;
                    count_next    = count_reg + CNT_W'(1);
                end
            end
            OP_POP_FRONT, OP_POP_BACK, OP_PEEK_FRONT, OP_PEEK_BACK:
            begin
                if (is_empty)
                begin
                    req_status = STS_EMPTY;
                end
                else
                begin
                    need_read = 1'b1;
                    case (op_t'(opcode))
                        OP_POP_FRONT:
                        begin
                            ram_cmd.raddr = front_reg;
                            front_next    = front_inc;
                            count_next    = count_reg - CNT_W'(1);
                        end
                        OP_POP_BACK:
                        begin
                            ram_cmd.raddr = back_dec;
                            back_next     = back_dec;
                            count_next    = count_reg - CNT_W'(1);
                        end
                        OP_PEEK_FRONT:
                        begin
                            ram_cmd.raddr = front_reg;
                        end
                        default:
                        begin
                            ram_cmd.raddr = back_dec;
                        end
                    endcase
                end
            end
            default:
            begin
            end
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && need_read)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // output register loading
    always_comb
    begin
        out_valid_next  = out_valid_reg && !m_ready;
        out_value_next  = out_value_reg;
        out_status_next = out_status_reg;
        out_count_next  = out_count_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    out_valid_next  = !need_read;
                    out_value_next  = '0;
                    out_status_next = req_status;
                    out_count_next  = COUNT_W'(count_next);
                end
            end
            S_READ:
            begin
                out_valid_next = 1'b1;
                out_value_next = VALUE_W'(ram_rdata);
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            front_reg     <= '0;
            back_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (accept)
            begin
                front_reg <= front_next;
                back_reg  <= back_next;
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_value_reg  <= out_value_next;
        out_status_reg <= out_status_next;
        out_count_reg  <= out_count_next;
    end

    assign result.valid  = out_valid_reg;
    assign result.value  = out_value_reg;
    assign result.status = out_status_reg;
    assign result.count  = out_count_reg;

    // count never exceeds capacity
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count above capacity");

    // read cycle always finds the output register empty
    a_read_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_READ) |-> !out_valid_reg)
        else $error("read data would overwrite a pending result");

    // no new transaction while a read is in flight
    a_no_accept_in_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_READ) |-> !s_ready)
        else $error("accept during memory read");

    // front plus count lands on back, modulo depth
    a_ring_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        ((32'(front_reg) + 32'(count_reg)) % DEPTH) == 32'(back_reg))
        else $error("ring indices and count disagree");

    // a successful push writes the slot memory
    a_push_writes: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !need_read && req_status == STS_OK && count_next != count_reg)
        |-> ram_cmd.we)
        else $error("count changed without a slot write");

endmodule

[design/bounded_deque_top.sv]
// ----------------------------------------------------------------------------
// bounded_deque_top
// Double-ended queue of fixed capacity held in a ring of RAM slots.
// ----------------------------------------------------------------------------
// Requests arrive on the s_ group (tvalid/tready/tdata); each one yields
// exactly one result transaction on the m_ group.
// A request pushes a word at either end, pops from either end or peeks at
// either end. The result carries the word read (zero for pushes, errors and
// unused opcodes), a status, an empty flag and the entry count afterwards.
// Pop or peek on an empty deque reports empty; push on a full deque reports
// full and drops the word. Neither changes the contents.
// Pushes, errors and unused opcodes are answered from the output register,
// loaded at the accept; pops and peeks first pass the registered read of the
// slot RAM in state S_READ. One request is in flight at a time: pushes take
// one request per cycle while results are taken; no request is taken in S_READ.
// The output register decouples the sides: a new request is taken in the
// same cycle the previous result is taken. If the receiver stalls, the
// result holds and new requests are refused until it drains.
// Reset empties the deque at once; no clearing pass is needed because only
// occupied slots are ever read.
// ----------------------------------------------------------------------------
module bounded_deque_top
    import bd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // opcode[2:0], push_value[34:3], zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // read_value[31:0], status[33:32],
                                   // is_empty[34], entry_count[39:35]
);

    ram_cmd_t              ram_cmd;
    logic [DATA_WIDTH-1:0] ram_rdata;
    result_t               result;

    bd_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_slots (
        .clk   (clk),
        .we    (ram_cmd.we),
        .waddr (ram_cmd.waddr),
        .wdata (ram_cmd.wdata),
        .raddr (ram_cmd.raddr),
        .rdata (ram_rdata)
    );

    bd_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_valid    (s_tvalid),
        .s_ready    (s_tready),
        .opcode     (s_tdata[2:0]),
        .push_value (s_tdata[34:3]),
        .ram_cmd    (ram_cmd),
        .ram_rdata  (ram_rdata),
        .m_ready    (m_tready),
        .result     (result)
    );

    assign m_tvalid = result.valid;
    assign m_tdata  = {result.count, (result.count == '0), result.status, result.value};

endmodule
